@@ rtl/core/teq_pkg.sv @@
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and codes for the timed event queue: cell data, cell control
// and result status codes.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int TickW  = 63;
    localparam int UnitW  = 6;
    localparam int StatW  = 3;
    localparam int FillW  = 7;

    localparam int QueueDepthDef = 64;

    localparam logic       OP_SCHEDULE = 1'b0;
    localparam logic       OP_POP      = 1'b1;

    localparam logic [StatW-1:0] ST_INSERTED  = 3'd0;
    localparam logic [StatW-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [StatW-1:0] ST_FULL      = 3'd2;
    localparam logic [StatW-1:0] ST_POPPED    = 3'd3;
    localparam logic [StatW-1:0] ST_NOT_DUE   = 3'd4;

    // What a cell shows its neighbors each cycle.
    typedef struct packed {
        logic             valid;
        logic             take;   // new entry belongs here or earlier
        logic [UnitW-1:0] unit;
        logic [TickW-1:0] tick;
    } t_cell_data;

    // Shift command common to all cells.
    typedef struct packed {
        logic cmp;   // latch compare flags against the incoming item
        logic ins;   // shift toward the tail and insert
        logic pop;   // shift toward the head
    } t_cell_ctl;

endpackage

@@ rtl/core/teq_cell.sv @@
// ----------------------------------------------------------------------------
// teq_cell
// One slot of the sorted queue. Holds an entry, compares it with the incoming
// item and shifts toward either neighbor on insert or pop.
// ----------------------------------------------------------------------------
module teq_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  teq_pkg::t_cell_ctl          i_ctl,
    input  logic [teq_pkg::TickW-1:0]   i_cmp_tick,
    input  logic [teq_pkg::UnitW-1:0]   i_cmp_unit,
    input  logic [teq_pkg::TickW-1:0]   i_new_tick,
    input  logic [teq_pkg::UnitW-1:0]   i_new_unit,
    input  teq_pkg::t_cell_data         i_prev,
    input  teq_pkg::t_cell_data         i_next,
    output teq_pkg::t_cell_data         o_data,
    output logic                        o_dup,
    output logic                        o_eq
);

    logic                      r_valid;
    logic                      r_take;
    logic                      r_dup;
    logic                      r_eq;
    logic [teq_pkg::TickW-1:0] r_tick;
    logic [teq_pkg::UnitW-1:0] r_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_take  <= 1'b0;
            r_dup   <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_take <= !r_valid || (r_tick >= i_cmp_tick);
                r_eq   <= r_tick == i_cmp_tick;
                r_dup  <= r_valid && (r_tick == i_cmp_tick) && (r_unit == i_cmp_unit);
            end
            if (i_ctl.ins) begin
                r_valid <= r_valid | i_prev.valid;
            end else if (i_ctl.pop) begin
                r_valid <= i_next.valid;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_prev.take) begin
                r_tick <= i_prev.tick;
                r_unit <= i_prev.unit;
            end else if (r_take) begin
                r_tick <= i_new_tick;
                r_unit <= i_new_unit;
            end
        end else if (i_ctl.pop) begin
            r_tick <= i_next.tick;
            r_unit <= i_next.unit;
        end
    end

    assign o_data = '{valid: r_valid, take: r_take, unit: r_unit, tick: r_tick};
    assign o_dup  = r_dup;
    assign o_eq   = r_eq;

endmodule

@@ rtl/core/timed_event_queue_unit.sv @@
// ----------------------------------------------------------------------------
// timed_event_queue_unit
// Wake-up schedule of (tick, unit id) entries kept sorted by tick in a chain
// of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: opcode 0
//   schedules (i_tick, i_unit_id) ahead of entries with the same tick, opcode
//   1 pops the head if its tick equals i_tick. Output channel (o_out_valid /
//   i_out_stall) returns one result per item: status, popped unit, head tick
//   and valid, fill count after the item.
//   Each item is handled in a compare step, which latches the compare flags in
//   every cell, and then a shift step, which reduces the duplicate flags and
//   shifts the chain. A new item is not accepted until the last one has
//   shifted; the result is registered with the shift.
//   The output register holds a result while i_out_stall is high; an item
//   already compared waits for it to drain before shifting, and the input
//   stalls meanwhile.
//   Reset clears all valid flags and the fill count; the queue is empty and
//   ready when reset is released.
// ----------------------------------------------------------------------------
module timed_event_queue_unit #(
    parameter int QUEUE_DEPTH = teq_pkg::QueueDepthDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [teq_pkg::UnitW-1:0]     i_unit_id,
    input  logic [teq_pkg::TickW-1:0]     i_tick,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [teq_pkg::StatW-1:0]     o_status,
    output logic [teq_pkg::UnitW-1:0]     o_popped_unit,
    output logic                          o_head_valid,
    output logic [teq_pkg::TickW-1:0]     o_head_tick,
    output logic [teq_pkg::FillW-1:0]     o_fill
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    teq_pkg::t_cell_data          cell_data [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]       dup_vec;
    logic [QUEUE_DEPTH-1:0]       eq_vec;
    teq_pkg::t_cell_ctl           ctl;

    logic                         r_cmp_valid;
    logic                         r_op;
    logic [teq_pkg::UnitW-1:0]    r_unit;
    logic [teq_pkg::TickW-1:0]    r_tick;
    logic [CntW-1:0]              r_count;
    logic [CntW-1:0]              n_count;

    logic                         r_out_valid;
    logic [teq_pkg::StatW-1:0]    r_status;
    logic [teq_pkg::UnitW-1:0]    r_popped;
    logic                         r_head_valid;
    logic [teq_pkg::TickW-1:0]    r_head_tick;
    logic [teq_pkg::FillW-1:0]    r_fill;

    logic                         accept;
    logic                         apply;
    logic                         dup;
    logic                         full;
    logic                         due;
    logic [teq_pkg::StatW-1:0]    n_status;
    logic                         n_head_valid;
    logic [teq_pkg::TickW-1:0]    n_head_tick;

    assign o_in_stall = r_cmp_valid;
    assign accept     = i_in_valid && !r_cmp_valid;
    assign apply      = r_cmp_valid && (!r_out_valid || !i_out_stall);

    assign dup  = |dup_vec;
    assign full = r_count == CntW'(QUEUE_DEPTH);
    assign due  = cell_data[0].valid && eq_vec[0];

    assign ctl.cmp = accept;
    assign ctl.ins = apply && (r_op == teq_pkg::OP_SCHEDULE) && !dup && !full;
    assign ctl.pop = apply && (r_op == teq_pkg::OP_POP) && due;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            teq_pkg::t_cell_data prev_d;
            teq_pkg::t_cell_data next_d;
            if (g == 0) begin : g_first
                // head sees an always-valid, never-taking neighbor
                assign prev_d = '{valid: 1'b1, take: 1'b0, unit: '0, tick: '0};
            end else begin : g_mid
                assign prev_d = cell_data[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign next_d = '{valid: 1'b0, take: 1'b0, unit: '0, tick: '0};
            end else begin : g_body
                assign next_d = cell_data[g+1];
            end
            teq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_cmp_tick (i_tick),
                .i_cmp_unit (i_unit_id),
                .i_new_tick (r_tick),
                .i_new_unit (r_unit),
                .i_prev     (prev_d),
                .i_next     (next_d),
                .o_data     (cell_data[g]),
                .o_dup      (dup_vec[g]),
                .o_eq       (eq_vec[g])
            );
        end
    endgenerate

    always_comb begin
        n_count      = r_count;
        n_head_valid = cell_data[0].valid;
        n_head_tick  = cell_data[0].tick;
        if (r_op == teq_pkg::OP_SCHEDULE) begin
            if (dup) begin
                n_status = teq_pkg::ST_DUPLICATE;
            end else if (full) begin
                n_status = teq_pkg::ST_FULL;
            end else begin
                n_status     = teq_pkg::ST_INSERTED;
                n_count      = r_count + 1'b1;
                n_head_valid = 1'b1;
                if (cell_data[0].take) begin
                    n_head_tick = r_tick;
                end
            end
        end else begin
            if (due) begin
                n_status     = teq_pkg::ST_POPPED;
                n_count      = r_count - 1'b1;
                n_head_valid = cell_data[1].valid;
                n_head_tick  = cell_data[1].tick;
            end else begin
                n_status = teq_pkg::ST_NOT_DUE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_cmp_valid <= 1'b1;
            end else if (apply) begin
                r_cmp_valid <= 1'b0;
            end
            if (apply) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_opcode;
            r_unit <= i_unit_id;
            r_tick <= i_tick;
        end
        if (apply) begin
            r_status     <= n_status;
            r_popped     <= ctl.pop ? cell_data[0].unit : '0;
            r_head_valid <= n_head_valid;
            r_head_tick  <= n_head_valid ? n_head_tick : '0;
            r_fill       <= teq_pkg::FillW'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_popped_unit = r_popped;
    assign o_head_valid  = r_head_valid;
    assign o_head_tick   = r_head_tick;
    assign o_fill        = r_fill;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_data[0].valid == (r_count != '0))
        else $error("head valid disagrees with count");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow count");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.pop |-> (cell_data[0].valid && !ctl.ins))
        else $error("pop from empty queue");

endmodule

@@ dv/teq_wake_sched_pkg.sv @@
// ----------------------------------------------------------------------------
// teq_wake_sched_pkg
// Result layout and a self-checking model of the wake-up schedule. The model
// keeps its own sorted copy of the queue, predicts one result per accepted
// item and compares every returned result against the oldest prediction.
// ----------------------------------------------------------------------------
package teq_wake_sched_pkg;

    import teq_pkg::*;

    localparam int SchedDepth = QueueDepthDef;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [UnitW-1:0] popped_unit;
        logic             head_valid;
        logic [TickW-1:0] head_tick;
        logic [FillW-1:0] fill;
    } sched_result_t;

    class wake_sched_checker;

        logic [TickW-1:0] slot_tick [SchedDepth];
        logic [UnitW-1:0] slot_unit [SchedDepth];
        int               held = 0;
        sched_result_t    awaited_results [$];
        int               errors = 0;
        int               items_seen = 0;
        int               results_seen = 0;
        int               peak_fill = 0;
        int               status_tally [5] = '{0, 0, 0, 0, 0};

        // Predict the result of one accepted item and advance the schedule copy.
        function void apply_request(logic op, logic [UnitW-1:0] unit,
                                    logic [TickW-1:0] tick);
            sched_result_t r;
            int            pos;
            bit            dup;
            r   = '0;
            pos = held;
            dup = 1'b0;
            if (op == OP_SCHEDULE) begin
                for (int i = 0; i < held; i++)
                    if (slot_tick[i] == tick && slot_unit[i] == unit) dup = 1'b1;
                if (dup) begin
                    r.status = ST_DUPLICATE;
                end else if (held >= SchedDepth) begin
                    r.status = ST_FULL;
                end else begin
                    // first slot whose tick is not below the new one
                    for (int i = held - 1; i >= 0; i--)
                        if (slot_tick[i] >= tick) pos = i;
                    for (int i = held; i > pos; i--) begin
                        slot_tick[i] = slot_tick[i-1];
                        slot_unit[i] = slot_unit[i-1];
                    end
                    slot_tick[pos] = tick;
                    slot_unit[pos] = unit;
                    held++;
                    r.status = ST_INSERTED;
                end
            end else if (held == 0 || slot_tick[0] != tick) begin
                r.status = ST_NOT_DUE;
            end else begin
                r.popped_unit = slot_unit[0];
                for (int i = 1; i < held; i++) begin
                    slot_tick[i-1] = slot_tick[i];
                    slot_unit[i-1] = slot_unit[i];
                end
                held--;
                r.status = ST_POPPED;
            end
            r.head_valid = (held > 0);
            r.head_tick  = (held > 0) ? slot_tick[0] : '0;
            r.fill       = FillW'(held);
            if (held > peak_fill) peak_fill = held;
            status_tally[r.status]++;
            items_seen++;
            awaited_results.push_back(r);
        endfunction

        function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual status %0d fill %0d",
                         $time, got.status, got.fill);
                return;
            end
            want = awaited_results.pop_front();
            cmp_field("status", 64'(want.status), 64'(got.status));
            cmp_field("popped_unit", 64'(want.popped_unit), 64'(got.popped_unit));
            cmp_field("head_valid", 64'(want.head_valid), 64'(got.head_valid));
            cmp_field("head_tick", 64'(want.head_tick), 64'(got.head_tick));
            cmp_field("fill", 64'(want.fill), 64'(got.fill));
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

    endclass

endpackage

@@ dv/tb_timed_event_queue_unit.sv @@
// ----------------------------------------------------------------------------
// tb_timed_event_queue_unit
// Drives schedule and pop items into the timed event queue under several
// idle/stall mixes: a directed pass over edge ticks, equal-tick ordering,
// duplicates and pops that are not due, then random traffic with fill-to-full
// bursts. Every result is checked against a predicted schedule.
// ----------------------------------------------------------------------------
module tb_timed_event_queue_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import teq_pkg::*;
    import teq_wake_sched_pkg::*;

    localparam logic [TickW-1:0] TickMax   = {TickW{1'b1}};
    localparam int               QuietLimit = 5000;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             i_opcode    = OP_SCHEDULE;
    logic [UnitW-1:0] i_unit_id   = '0;
    logic [TickW-1:0] i_tick      = '0;
    logic             i_out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [StatW-1:0] o_status;
    logic [UnitW-1:0] o_popped_unit;
    logic             o_head_valid;
    logic [TickW-1:0] o_head_tick;
    logic [FillW-1:0] o_fill;

    wake_sched_checker sched;
    int                idle_pct  = 0;
    int                stall_pct = 0;
    int                quiet_cycles = 0;
    int                n_sent = 0;
    logic [TickW-1:0]  base_tick = '0;

    timed_event_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_unit_id     (i_unit_id),
        .i_tick        (i_tick),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_popped_unit (o_popped_unit),
        .o_head_valid  (o_head_valid),
        .o_head_tick   (o_head_tick),
        .o_fill        (o_fill)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // result monitor and no-progress watchdog
    always @(posedge i_clk) begin : monitor
        sched_result_t seen;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen = '{o_status, o_popped_unit, o_head_valid, o_head_tick, o_fill};
                sched.check_result(seen);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QuietLimit) begin
                $display("%0t no handshake for %0d cycles", $time, QuietLimit);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_item(input logic op, input logic [UnitW-1:0] unit,
                             input logic [TickW-1:0] tick);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_unit_id  <= unit;
        i_tick     <= tick;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sched.apply_request(op, unit, tick);
        n_sent++;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // hold the sender off until every outstanding result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sched.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [TickW-1:0] rand_tick();
        return TickW'({$urandom, $urandom});
    endfunction

    function automatic logic [TickW-1:0] pick_base();
        logic [TickW-1:0] b;
        int               r;
        r = $urandom_range(99);
        if (r < 20) return '0;
        if (r < 30) return TickMax - 40;
        b = rand_tick();
        return (b > TickMax - 40) ? TickMax - 40 : b;
    endfunction

    task automatic pop_head_or_miss(input int miss_pct);
        logic [TickW-1:0] t;
        t = (sched.held > 0) ? sched.slot_tick[0] : rand_tick();
        if ($urandom_range(99) < miss_pct) begin
            case ($urandom_range(2))
                0:       t = t + 1;
                1:       t = t - 1;
                default: t = rand_tick();
            endcase
        end
        send_item(OP_POP, UnitW'($urandom_range(63)), t);
    endtask

    // fill the schedule to the top, poke it while full, then drain it
    task automatic fill_burst();
        int guard;
        int idx;
        guard = 0;
        base_tick = pick_base();
        while (sched.held < SchedDepth && guard < 300) begin
            send_item(OP_SCHEDULE, UnitW'($urandom_range(63)),
                      base_tick + TickW'($urandom_range(15)));
            guard++;
        end
        idx = $urandom_range(sched.held - 1);
        send_item(OP_SCHEDULE, sched.slot_unit[idx], sched.slot_tick[idx]);
        send_item(OP_SCHEDULE, UnitW'($urandom_range(63)), rand_tick());
        send_item(OP_SCHEDULE, UnitW'($urandom_range(63)), base_tick + 16);
        while (sched.held > 0) pop_head_or_miss(15);
    endtask

    task automatic random_step();
        int r;
        int idx;
        r = $urandom_range(99);
        if (r < 5) begin
            base_tick = pick_base();
        end else if (r < 58) begin
            if (sched.held > 0 && $urandom_range(99) < 15) begin
                idx = $urandom_range(sched.held - 1);
                send_item(OP_SCHEDULE, sched.slot_unit[idx], sched.slot_tick[idx]);
            end else if ($urandom_range(99) < 30) begin
                send_item(OP_SCHEDULE, UnitW'($urandom_range(3)),
                          base_tick + TickW'($urandom_range(3)));
            end else begin
                send_item(OP_SCHEDULE, UnitW'($urandom_range(63)),
                          base_tick + TickW'($urandom_range(31)));
            end
        end else begin
            pop_head_or_miss(25);
        end
    endtask

    initial begin
        int idle_mix [4]  = '{0, 76, 0, 23};
        int stall_mix [4] = '{0, 0, 76, 23};
        sched = new;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pops, extreme ticks, equal-tick order, duplicates,
        // pops earlier and later than the head, alternating bit patterns
        send_item(OP_POP, 6'd0, '0);
        send_item(OP_POP, 6'd63, TickMax);
        send_item(OP_SCHEDULE, 6'd63, TickMax);
        send_item(OP_SCHEDULE, 6'd0, '0);
        send_item(OP_SCHEDULE, 6'd0, '0);
        send_item(OP_SCHEDULE, 6'd42, '0);
        send_item(OP_SCHEDULE, 6'd63, TickMax);
        send_item(OP_POP, 6'd0, TickW'(1));
        send_item(OP_POP, 6'd0, '0);
        send_item(OP_POP, 6'd0, '0);
        send_item(OP_SCHEDULE, 6'd7, TickW'(1000));
        send_item(OP_POP, 6'd0, TickW'(999));
        send_item(OP_POP, 6'd0, TickW'(1001));
        send_item(OP_POP, 6'd0, TickW'(1000));
        send_item(OP_POP, 6'd0, TickMax);
        send_item(OP_SCHEDULE, 6'h2A, TickW'({(TickW+1)/2{2'b10}}));
        send_item(OP_SCHEDULE, 6'h15, TickW'({(TickW+1)/2{2'b01}}));
        send_item(OP_SCHEDULE, 6'h15, TickW'({(TickW+1)/2{2'b10}}));
        send_item(OP_POP, 6'h3F, TickW'({(TickW+1)/2{2'b10}}));
        send_item(OP_POP, 6'h3F, TickW'({(TickW+1)/2{2'b10}}));
        send_item(OP_POP, 6'h3F, TickW'({(TickW+1)/2{2'b01}}));
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_mix[ph];
            stall_pct = stall_mix[ph];
            fill_burst();
            while (n_sent < 21 + (ph + 1) * 458) begin
                if ($urandom_range(99) < 3) fill_burst();
                else random_step();
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("%0d items, %0d results; inserted %0d, duplicate %0d, full %0d",
                 sched.items_seen, sched.results_seen, sched.status_tally[ST_INSERTED],
                 sched.status_tally[ST_DUPLICATE], sched.status_tally[ST_FULL]);
        $display("popped %0d, not due %0d, peak fill %0d, four idle/stall mixes",
                 sched.status_tally[ST_POPPED], sched.status_tally[ST_NOT_DUE],
                 sched.peak_fill);
        if (sched.errors == 0 && sched.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sched.errors, sched.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
